### src/gcdsc_pkg.sv
// Shared types and constants for the gcd_with_step_count block.
// Used by gcdsc_ctrl, gcdsc_datapath and the top level; no dependencies.
package gcdsc_pkg;

    localparam int WIDTH_DEFAULT = 32;
    localparam int STEP_W        = 6;
    localparam logic [STEP_W-1:0] STEP_MAX = '1;

    // Controller to datapath
    typedef struct packed {
        logic load;       // take operand magnitudes, larger first
        logic start_div;  // begin a remainder of larger by smaller
        logic shift;      // one restoring remainder bit
        logic update;     // larger <= smaller, smaller <= remainder, count up
        logic capture;    // move the result into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic smaller_zero;
        logic bit_last;
    } status_t;

endpackage

### src/gcd_with_step_count.sv
// Greatest common divisor of two signed operands' magnitudes, with the count
// of Euclid modulo steps taken.
//
// Input channel s_: s_valid/s_ready carry one beat holding s_first_value and
// s_second_value (two's complement). Result channel m_: m_valid/m_ready carry
// m_divisor (unsigned) and m_step_count (saturates at 63).
// One item is worked at a time; s_ready is high only while the loop is idle.
// Each modulo step is one check state, a shift state per bit of WIDTH in the
// one-bit-per-cycle restoring remainder unit and one update state, and a last
// check state captures the result once the output register is free. The loop
// is idle again as m_valid rises, so the next beat can be accepted from then
// on. At WIDTH 32 at most 44 steps occur (consecutive Fibonacci operands).
// The result sits in an output register, so a new beat is accepted while an
// earlier result waits for m_ready; a finished result then holds in the loop
// until the output register frees up.
// Reset (aresetn, synchronous, active low) returns the block to idle and
// drops any pending result.
module gcd_with_step_count #(
    parameter int WIDTH = gcdsc_pkg::WIDTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [WIDTH-1:0]        s_first_value,
    input  logic signed [WIDTH-1:0]        s_second_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic        [WIDTH-1:0]        m_divisor,
    output logic [gcdsc_pkg::STEP_W-1:0]   m_step_count
);

    gcdsc_pkg::cmd_t    cmd;
    gcdsc_pkg::status_t status;

    gcdsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    gcdsc_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_first_value  (s_first_value),
        .s_second_value (s_second_value),
        .m_divisor      (m_divisor),
        .m_step_count   (m_step_count),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

### src/gcdsc_ctrl.sv
// Sequencer for the Euclid loop: load, remainder iterations, update, output.
// Depends on gcdsc_pkg for the command and status structs.
module gcdsc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output gcdsc_pkg::cmd_t   cmd,
    input  gcdsc_pkg::status_t status
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.smaller_zero) begin
                    // hold until the output register can take the beat
                    if (out_free) begin
                        cmd.capture  = 1'b1;
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.shift = 1'b1;
                if (status.bit_last) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### src/gcdsc_datapath.sv
// Working registers, one-bit-per-cycle restoring remainder unit, step counter
// and output register. Depends on gcdsc_pkg.
module gcdsc_datapath #(
    parameter int WIDTH = gcdsc_pkg::WIDTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic signed [WIDTH-1:0]        s_first_value,
    input  logic signed [WIDTH-1:0]        s_second_value,
    output logic        [WIDTH-1:0]        m_divisor,
    output logic [gcdsc_pkg::STEP_W-1:0]   m_step_count,
    input  gcdsc_pkg::cmd_t                cmd,
    output gcdsc_pkg::status_t             status
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0]             larger_reg, smaller_reg;
    logic [WIDTH-1:0]             rem_reg, dvd_reg;
    logic [CNT_W-1:0]             bit_cnt_reg;
    logic [gcdsc_pkg::STEP_W-1:0] steps_reg;
    logic [WIDTH-1:0]             divisor_reg;
    logic [gcdsc_pkg::STEP_W-1:0] count_out_reg;

    logic [WIDTH-1:0] mag_a, mag_b;
    logic [WIDTH:0]   shifted, trial;
    logic [WIDTH-1:0] rem_next;

    // the most negative value maps to 2^(WIDTH-1) as an unsigned magnitude
    assign mag_a = s_first_value[WIDTH-1]  ? WIDTH'(0) - WIDTH'(s_first_value)
                                           : WIDTH'(s_first_value);
    assign mag_b = s_second_value[WIDTH-1] ? WIDTH'(0) - WIDTH'(s_second_value)
                                           : WIDTH'(s_second_value);

    assign shifted  = {rem_reg, dvd_reg[WIDTH-1]};
    assign trial    = shifted - {1'b0, smaller_reg};
    // keep the shifted value on borrow, else the difference
    assign rem_next = trial[WIDTH] ? shifted[WIDTH-1:0] : trial[WIDTH-1:0];

    assign status.smaller_zero = (smaller_reg == '0);
    assign status.bit_last     = (bit_cnt_reg == '0);

    assign m_divisor    = divisor_reg;
    assign m_step_count = count_out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            if (mag_a >= mag_b) begin
                larger_reg  <= mag_a;
                smaller_reg <= mag_b;
            end else begin
                larger_reg  <= mag_b;
                smaller_reg <= mag_a;
            end
        end else if (cmd.update) begin
            larger_reg  <= smaller_reg;
            smaller_reg <= rem_reg;
        end

        if (cmd.start_div) begin
            rem_reg     <= '0;
            dvd_reg     <= larger_reg;
            bit_cnt_reg <= CNT_W'(WIDTH - 1);
        end else if (cmd.shift) begin
            rem_reg     <= rem_next;
            dvd_reg     <= {dvd_reg[WIDTH-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg - 1'b1;
        end

        if (cmd.capture) begin
            divisor_reg   <= larger_reg;
            count_out_reg <= steps_reg;
        end
    end

    // step counter saturates at its top code
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg <= '0;
        end else if (cmd.load) begin
            steps_reg <= '0;
        end else if (cmd.update && steps_reg != gcdsc_pkg::STEP_MAX) begin
            steps_reg <= steps_reg + 1'b1;
        end
    end

endmodule

### tb/sv/gcd_with_step_count_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for gcd_with_step_count: directed table, then random operand pairs.
// Depends on gcdsc_pkg and the gcd_with_step_count top level only.
module gcd_with_step_count_tb;

    localparam int W            = gcdsc_pkg::WIDTH_DEFAULT;
    localparam int NUM_DIRECTED = 18;
    localparam int NUM_RANDOM   = 372;
    localparam int LONG_HOLD    = 4000;   // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 1600;   // worst-case latency plus margin
    localparam logic [W-1:0] MIN_VALUE = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAX_VALUE = {1'b0, {(W-1){1'b1}}};

    typedef struct packed {
        logic [W-1:0]                 divisor;
        logic [gcdsc_pkg::STEP_W-1:0] steps;
    } gcd_steps_t;

    typedef struct packed {
        logic [W-1:0] first;
        logic [W-1:0] second;
        logic         known;   // want holds a hand-checked result
        gcd_steps_t   want;
    } euclid_case_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic [W-1:0]                 s_first_value;
    logic [W-1:0]                 s_second_value;
    logic                         m_valid;
    logic                         m_ready;
    logic [W-1:0]                 m_divisor;
    logic [gcdsc_pkg::STEP_W-1:0] m_step_count;

    gcd_steps_t   pending_gcds[$];
    int           mismatch_count = 0;
    int           sender_quiet   = 0;
    logic [W-1:0] fib_seq [0:47];
    logic [W-1:0] corner_values [5];

    euclid_case_t directed_cases [NUM_DIRECTED] = '{
        '{W'(0),        W'(0),          1'b1, '{W'(0), 6'd0}},
        '{W'(0),        W'(5),          1'b1, '{W'(5), 6'd0}},
        '{-W'(7),       W'(0),          1'b1, '{W'(7), 6'd0}},
        '{MIN_VALUE,    W'(0),          1'b1, '{MIN_VALUE, 6'd0}},
        '{W'(0),        MIN_VALUE,      1'b1, '{MIN_VALUE, 6'd0}},
        '{MIN_VALUE,    MIN_VALUE,      1'b1, '{MIN_VALUE, 6'd1}},
        '{MAX_VALUE,    MAX_VALUE,      1'b1, '{MAX_VALUE, 6'd1}},
        '{MAX_VALUE,    MIN_VALUE,      1'b1, '{W'(1), 6'd2}},
        '{MIN_VALUE,    W'(1),          1'b1, '{W'(1), 6'd1}},
        '{-W'(1),       -W'(1),         1'b1, '{W'(1), 6'd1}},
        '{MIN_VALUE,    -MAX_VALUE,     1'b1, '{W'(1), 6'd2}},
        '{MIN_VALUE,    W'(32'h4000_0000), 1'b1, '{W'(32'h4000_0000), 6'd1}},
        '{W'(12),       W'(18),         1'b0, '{W'(0), 6'd0}},
        '{-W'(12),      W'(18),         1'b0, '{W'(0), 6'd0}},
        '{W'(18),       -W'(12),        1'b0, '{W'(0), 6'd0}},
        '{W'(1071),     W'(462),        1'b0, '{W'(0), 6'd0}},
        // consecutive Fibonacci numbers: the longest chain of steps
        '{W'(1836311903),  W'(1134903170),  1'b0, '{W'(0), 6'd0}},
        '{-W'(1134903170), -W'(1836311903), 1'b0, '{W'(0), 6'd0}}
    };

    gcd_with_step_count #(
        .WIDTH(W)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_first_value  (s_first_value),
        .s_second_value (s_second_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_divisor      (m_divisor),
        .m_step_count   (m_step_count)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic gcd_steps_t euclid_gcd(logic [W-1:0] first, logic [W-1:0] second);
        logic [W-1:0]                 mag_a;
        logic [W-1:0]                 mag_b;
        logic [W-1:0]                 big;
        logic [W-1:0]                 little;
        logic [W-1:0]                 rem;
        logic [gcdsc_pkg::STEP_W-1:0] steps;
        gcd_steps_t                   res;
        mag_a = first[W-1]  ? -first  : first;
        mag_b = second[W-1] ? -second : second;
        big    = (mag_a >= mag_b) ? mag_a : mag_b;
        little = (mag_a >= mag_b) ? mag_b : mag_a;
        steps  = '0;
        while (little != 0) begin
            rem    = big % little;
            big    = little;
            little = rem;
            if (steps != gcdsc_pkg::STEP_MAX)
                steps++;
        end
        res.divisor = big;
        res.steps   = steps;
        return res;
    endfunction

    // Draws a random idle gap, with occasional runs of back-to-back beats.
    function automatic int draw_idle(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
            quiet_left = $urandom_range(10, 30);
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [W-1:0] random_sign(logic [W-1:0] v);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // Leaves s_valid high after acceptance; the next call lowers it only for a gap.
    task automatic offer_operands(input logic [W-1:0] first, input logic [W-1:0] second,
                                  input logic known, input gcd_steps_t want);
        int gap;
        gap = draw_idle(sender_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_first_value  <= first;
        s_second_value <= second;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_gcds.push_back(known ? want : euclid_gcd(first, second));
    endtask

    initial begin
        logic [W-1:0] op_a;
        logic [W-1:0] op_b;
        logic [W-1:0] factor;
        int           k;
        s_valid        <= 1'b0;
        s_first_value  <= '0;
        s_second_value <= '0;
        aresetn        <= 1'b0;
        fib_seq[0] = '0;
        fib_seq[1] = W'(1);
        for (int i = 2; i < 48; i++)
            fib_seq[i] = fib_seq[i-1] + fib_seq[i-2];
        corner_values = '{W'(0), MIN_VALUE, MAX_VALUE, W'(1), '1};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_cases[i])
            offer_operands(directed_cases[i].first, directed_cases[i].second,
                           directed_cases[i].known, directed_cases[i].want);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            case ($urandom_range(0, 9))
                4, 5: begin
                    op_a = random_sign(W'($urandom_range(0, 255)));
                    op_b = random_sign(W'($urandom_range(0, 255)));
                end
                6: begin
                    // shared factor so the divisor is large
                    factor = W'($urandom_range(1, 65535));
                    op_a = random_sign(factor * W'($urandom_range(0, 32767)));
                    op_b = random_sign(factor * W'($urandom_range(0, 32767)));
                end
                7: begin
                    k    = $urandom_range(2, 45);
                    op_a = random_sign(fib_seq[k+1]);
                    op_b = random_sign(fib_seq[k]);
                end
                8: begin
                    op_a = corner_values[$urandom_range(0, 4)];
                    op_b = W'($urandom());
                end
                9: begin
                    op_a = W'($urandom());
                    op_b = random_sign(op_a);
                end
                default: begin
                    op_a = W'($urandom());
                    op_b = W'($urandom());
                end
            endcase
            if ($urandom_range(0, 1))
                offer_operands(op_a, op_b, 1'b0, '0);
            else
                offer_operands(op_b, op_a, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (pending_gcds.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        int         stall;
        int         quiet;
        int         taken;
        gcd_steps_t want;
        m_ready <= 1'b0;
        quiet = 0;
        taken = 0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            // hold off long enough for the block to fill and drop s_ready
            stall = (taken == 25 || taken == 250) ? LONG_HOLD : draw_idle(quiet);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (pending_gcds.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with none expected: divisor %0d step_count %0d",
                         $time, m_divisor, m_step_count);
            end else begin
                want = pending_gcds.pop_front();
                if (m_divisor !== want.divisor) begin
                    mismatch_count++;
                    $display("%0t: divisor expected %0d actual %0d",
                             $time, want.divisor, m_divisor);
                end
                if (m_step_count !== want.steps) begin
                    mismatch_count++;
                    $display("%0t: step_count expected %0d actual %0d",
                             $time, want.steps, m_step_count);
                end
            end
            taken++;
        end
    end

    // About five times the slowest legal run.
    initial begin
        #30_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
